FILE: sv/mlqs_pkg.sv
// Shared types and constants for the multilevel queue scheduler.
package mlqs_pkg;

   // Store capacity and derived index widths.
   localparam int MAX_PROCS  = 32;
   localparam int IDX_W      = $clog2(MAX_PROCS);
   localparam int CNT_W      = $clog2(MAX_PROCS + 1);

   // Time arithmetic saturates at the top of a 22-bit tick count.
   localparam int TIME_W     = 22;
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   // Depth of the queue between the front and back parts.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   // One input record as it arrives on the request channel.
   typedef struct packed {
      logic [15:0] proc_id;
      logic [15:0] arrival;
      logic [15:0] burst;
      logic        kind;
      logic        last;
   } req_type;

   // One result as it leaves on the response channel.
   typedef struct packed {
      logic [15:0]       out_proc_id;
      logic [15:0]       out_arrival;
      logic [15:0]       out_burst;
      logic [TIME_W-1:0] completion;
      logic [TIME_W-1:0] turnaround;
      logic [TIME_W-1:0] waiting;
      logic              out_last;
   } rsp_type;

   // A record as held in the process store.
   typedef struct packed {
      logic [15:0] proc_id;
      logic [15:0] arrival;
      logic [15:0] burst;
      logic        kind;
   } rec_type;

   // A classified record as it travels through the queue.
   typedef struct packed {
      rec_type          rec;
      logic [IDX_W-1:0] idx;
      logic             keep;
      logic             last;
      logic [CNT_W-1:0] run_count;
   } qent_type;

   // Sequencer states of the back part.
   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_PICK,
      ST_OUT
   } st_type;

endpackage

FILE: sv/mlqs_front.sv
// Front part: accepts records, assigns store slots and marks overflow.
module mlqs_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  mlqs_pkg::req_type  req_data,
   output logic               push,
   output mlqs_pkg::qent_type push_data,
   input  logic               q_full
);
   import mlqs_pkg::*;

   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             keep;
   logic [CNT_W-1:0] cnt_next;

   // A transfer is taken whenever the queue has room.
   assign req_ready = !q_full;
   assign push      = req_valid && req_ready;

   // Records beyond capacity are marked to be dropped.
   assign keep     = (cnt_ff < CNT_W'(MAX_PROCS));
   assign cnt_next = keep ? (cnt_ff + CNT_W'(1)) : cnt_ff;

   // Build the queue entry for the current record.
   always_comb begin
      push_data.rec.proc_id = req_data.proc_id;
      push_data.rec.arrival = req_data.arrival;
      push_data.rec.burst   = req_data.burst;
      push_data.rec.kind    = req_data.kind;
      push_data.idx         = cnt_ff[IDX_W-1:0];
      push_data.keep        = keep;
      push_data.last        = req_data.last;
      push_data.run_count   = cnt_next;
   end

   // Run length counter, restarted by the final record.
   always_comb begin
      cnt_in = cnt_ff;
      if (push) begin
         cnt_in = req_data.last ? '0 : cnt_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

FILE: sv/mlqs_fifo.sv
// Short queue that decouples the front part from the back part.
module mlqs_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  mlqs_pkg::qent_type wr_data,
   output logic               full,
   input  logic               rd_en,
   output mlqs_pkg::qent_type rd_data,
   output logic               empty
);
   import mlqs_pkg::*;

   qent_type           mem [FIFO_DEPTH];
   logic [FIFO_AW:0]   wr_ptr_ff;
   logic [FIFO_AW:0]   wr_ptr_in;
   logic [FIFO_AW:0]   rd_ptr_ff;
   logic [FIFO_AW:0]   rd_ptr_in;

   // Full and empty from the wrap bit of the pointers.
   assign empty = (wr_ptr_ff == rd_ptr_ff);
   assign full  = (wr_ptr_ff[FIFO_AW] != rd_ptr_ff[FIFO_AW]) &&
                  (wr_ptr_ff[FIFO_AW-1:0] == rd_ptr_ff[FIFO_AW-1:0]);
   assign rd_data = mem[rd_ptr_ff[FIFO_AW-1:0]];

   // Pointer advance.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (wr_en && !full) begin
         wr_ptr_in = wr_ptr_ff + (FIFO_AW + 1)'(1);
      end
      if (rd_en && !empty) begin
         rd_ptr_in = rd_ptr_ff + (FIFO_AW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (wr_en && !full) begin
         mem[wr_ptr_ff[FIFO_AW-1:0]] <= wr_data;
      end
   end

endmodule

FILE: sv/mlqs_back.sv
// Back part: stores records, schedules a run and streams the results.
module mlqs_back (
   input  logic               clock,
   input  logic               reset,
   input  mlqs_pkg::qent_type q_data,
   input  logic               q_empty,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output mlqs_pkg::rsp_type  rsp_data
);
   import mlqs_pkg::*;

   // Process store and completion store.
   rec_type           rec_mem  [MAX_PROCS];
   logic [TIME_W-1:0] comp_mem [MAX_PROCS];
   rec_type           rec_rd_ff;
   logic [TIME_W-1:0] comp_rd_ff;

   st_type                 state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       scan_ff, scan_in;
   logic [CNT_W-1:0]       picks_ff, picks_in;
   logic [CNT_W-1:0]       out_ff, out_in;
   logic [TIME_W-1:0]      tick_ff, tick_in;
   logic [MAX_PROCS-1:0]   served_ff, served_in;
   logic                   best_vld_ff, best_vld_in;
   logic [IDX_W-1:0]       best_idx_ff, best_idx_in;
   logic [16:0]            best_key_ff, best_key_in;
   logic [15:0]            best_burst_ff, best_burst_in;
   logic                   scan_tag_vld_ff, scan_tag_vld_in;
   logic [IDX_W-1:0]       tag_idx_ff, tag_idx_in;
   logic                   out_tag_vld_ff, out_tag_vld_in;
   logic                   out_tag_last_ff, out_tag_last_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   // Control decoded from the state.
   logic             wr_rec;
   logic             rd_en;
   logic             comp_we;
   logic             issue;
   logic [IDX_W-1:0] rd_addr;

   // Datapath helpers.
   logic [16:0]       cand_key;
   logic              cand_better;
   logic [TIME_W-1:0] start_time;
   logic [TIME_W:0]   end_sum;
   logic [TIME_W-1:0] pick_time;
   logic [TIME_W-1:0] tat;
   logic [TIME_W-1:0] burst_ext;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (!q_empty && q_data.last) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_ff == count_ff) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            state_in = ((picks_ff + CNT_W'(1)) == count_ff) ? ST_OUT : ST_SCAN;
         end
         ST_OUT: begin
            if (issue && ((out_ff + CNT_W'(1)) == count_ff)) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // State outputs.
   always_comb begin
      q_pop   = 1'b0;
      wr_rec  = 1'b0;
      rd_en   = 1'b0;
      comp_we = 1'b0;
      issue   = 1'b0;
      rd_addr = scan_ff[IDX_W-1:0];
      case (state_ff)
         ST_LOAD: begin
            q_pop  = !q_empty;
            wr_rec = !q_empty && q_data.keep;
         end
         ST_SCAN: begin
            rd_en = (scan_ff != count_ff);
         end
         ST_PICK: begin
            comp_we = 1'b1;
         end
         ST_OUT: begin
            // One read in flight, and only while the output register can take it.
            issue   = !out_tag_vld_ff && (!rsp_valid_ff || rsp_ready);
            rd_en   = issue;
            rd_addr = out_ff[IDX_W-1:0];
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   // Candidate comparison: system class first, then earliest arrival, then load order.
   assign cand_key    = {rec_rd_ff.kind, rec_rd_ff.arrival};
   assign cand_better = scan_tag_vld_ff && !served_ff[tag_idx_ff] &&
                        (!best_vld_ff || (cand_key < best_key_ff));

   // Completion of the chosen process, with the clock jumping to its arrival when idle.
   assign start_time = (tick_ff < {{(TIME_W-16){1'b0}}, best_key_ff[15:0]}) ?
                       {{(TIME_W-16){1'b0}}, best_key_ff[15:0]} : tick_ff;
   assign end_sum    = {1'b0, start_time} + {{(TIME_W-15){1'b0}}, best_burst_ff};
   assign pick_time  = (end_sum > {1'b0, TIME_MAX}) ? TIME_MAX : end_sum[TIME_W-1:0];

   // Turnaround and waiting for the result being formed.
   assign burst_ext = {{(TIME_W-16){1'b0}}, rec_rd_ff.burst};
   assign tat       = comp_rd_ff - {{(TIME_W-16){1'b0}}, rec_rd_ff.arrival};

   always_comb begin
      rsp_data_in.out_proc_id = rec_rd_ff.proc_id;
      rsp_data_in.out_arrival = rec_rd_ff.arrival;
      rsp_data_in.out_burst   = rec_rd_ff.burst;
      rsp_data_in.completion  = comp_rd_ff;
      rsp_data_in.turnaround  = tat;
      rsp_data_in.waiting     = (tat >= burst_ext) ? (tat - burst_ext) : '0;
      rsp_data_in.out_last    = out_tag_last_ff;
   end

   // Sequencer registers.
   always_comb begin
      count_in        = count_ff;
      scan_in         = scan_ff;
      picks_in        = picks_ff;
      out_in          = out_ff;
      tick_in         = tick_ff;
      served_in       = served_ff;
      best_vld_in     = best_vld_ff;
      best_idx_in     = best_idx_ff;
      best_key_in     = best_key_ff;
      best_burst_in   = best_burst_ff;
      scan_tag_vld_in = rd_en && (state_ff == ST_SCAN);
      tag_idx_in      = scan_ff[IDX_W-1:0];
      out_tag_vld_in  = issue;
      out_tag_last_in = ((out_ff + CNT_W'(1)) == count_ff);

      // A new run starts with the final record of the load.
      if (q_pop && q_data.last) begin
         count_in    = q_data.run_count;
         scan_in     = '0;
         picks_in    = '0;
         out_in      = '0;
         tick_in     = '0;
         best_vld_in = 1'b0;
      end

      if (rd_en && (state_ff == ST_SCAN)) begin
         scan_in = scan_ff + CNT_W'(1);
      end

      if (cand_better) begin
         best_vld_in   = 1'b1;
         best_idx_in   = tag_idx_ff;
         best_key_in   = cand_key;
         best_burst_in = rec_rd_ff.burst;
      end

      // Dispatch the chosen process and open the next search.
      if (comp_we) begin
         tick_in              = pick_time;
         served_in[best_idx_ff] = 1'b1;
         picks_in             = picks_ff + CNT_W'(1);
         scan_in              = '0;
         best_vld_in          = 1'b0;
      end

      if (issue) begin
         out_in = out_ff + CNT_W'(1);
         if ((out_ff + CNT_W'(1)) == count_ff) begin
            served_in = '0;
         end
      end
   end

   // Output register: loaded as read data arrives, emptied by a transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_tag_vld_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_LOAD;
         count_ff        <= '0;
         scan_ff         <= '0;
         picks_ff        <= '0;
         out_ff          <= '0;
         tick_ff         <= '0;
         served_ff       <= '0;
         best_vld_ff     <= 1'b0;
         scan_tag_vld_ff <= 1'b0;
         out_tag_vld_ff  <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         count_ff        <= count_in;
         scan_ff         <= scan_in;
         picks_ff        <= picks_in;
         out_ff          <= out_in;
         tick_ff         <= tick_in;
         served_ff       <= served_in;
         best_vld_ff     <= best_vld_in;
         scan_tag_vld_ff <= scan_tag_vld_in;
         out_tag_vld_ff  <= out_tag_vld_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      best_idx_ff     <= best_idx_in;
      best_key_ff     <= best_key_in;
      best_burst_ff   <= best_burst_in;
      tag_idx_ff      <= tag_idx_in;
      out_tag_last_ff <= out_tag_last_in;
      if (out_tag_vld_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Process store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_rec) begin
         rec_mem[q_data.idx] <= q_data.rec;
      end
      if (rd_en) begin
         rec_rd_ff <= rec_mem[rd_addr];
      end
   end

   // Completion store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (comp_we) begin
         comp_mem[best_idx_ff] <= pick_time;
      end
      if (rd_en) begin
         comp_rd_ff <= comp_mem[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A dispatch always has a chosen process.
   a_pick_has_best: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PICK) |-> best_vld_ff)
      else $error("dispatch without a chosen process");

   // No more processes dispatched than the run holds.
   a_served_bound: assert property (@(posedge clock) disable iff (reset)
      ($countones(served_ff) <= int'(count_ff)))
      else $error("more processes served than stored");

   // Read data for a result never meets an occupied output register.
   a_out_slot_free: assert property (@(posedge clock) disable iff (reset)
      out_tag_vld_ff |-> !rsp_valid_ff)
      else $error("result read while output register is occupied");

   // The scheduling clock stays within its saturating range.
   a_tick_range: assert property (@(posedge clock) disable iff (reset)
      (tick_ff <= TIME_MAX))
      else $error("scheduling clock out of range");

endmodule

FILE: sv/multilevel_queue_fcfs_scheduler.sv
// Top level of the two-class multilevel queue first-come-first-served scheduler.
//
// Usage: process records enter on the req_ channel, one transfer per cycle while
// the internal queue has room. Records are stored in load order; those beyond
// the store capacity are dropped. The record with last set starts a run: system
// class records run before user class records, each class in arrival order with
// ties in load order, without preemption, the clock jumping to an arrival when idle.
// Results leave on the rsp_ channel in load order, one per stored record, with
// out_last set on the final one.
// Loading pops the records from the queue into the store. Scheduling a run makes
// one linear search of the store (one entry read per cycle) for each dispatched
// process. Results then follow; each result's store read waits until the previous
// one has passed through the registered read port into the output register.
// While a run is scheduled, new records wait in the four-entry queue and then
// stall on req_ready. A stalled rsp_ready holds the current result and pauses
// the result stream. Reset empties the store and the queue and aborts any run.
module multilevel_queue_fcfs_scheduler (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mlqs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mlqs_pkg::rsp_type rsp_data
);
   import mlqs_pkg::*;

   logic     push;
   qent_type push_data;
   logic     q_full;
   logic     q_pop;
   qent_type q_data;
   logic     q_empty;

   // Front part: accept and classify.
   mlqs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .push      (push),
      .push_data (push_data),
      .q_full    (q_full)
   );

   // Queue between the two parts.
   mlqs_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (push_data),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_data (q_data),
      .empty   (q_empty)
   );

   // Back part: store, schedule and report.
   mlqs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_data    (q_data),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the two-class multilevel queue FCFS scheduler.
`timescale 1ns / 100ps

module tb;
   import mlqs_pkg::*;

   localparam int   CLK_HALF      = 4;
   localparam int   RESET_CYCLES  = 8;
   localparam int   CYCLE_LIMIT   = 200000;
   localparam int   HOLD_CYCLES   = 400;
   localparam int   SETTLE_CYCLES = 64;
   localparam int   TOTAL_ITEMS   = 165;
   localparam logic CLASS_SYSTEM  = 1'b0;
   localparam logic CLASS_USER    = 1'b1;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Predictor state: records of the run being loaded and the finish tick of each.
   req_type           loaded_recs[$];
   logic [TIME_W-1:0] finish_tick[MAX_PROCS];

   // Predicted results, oldest first.
   rsp_type           schedule_q[$];

   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int unsigned records_sent   = 0;
   int unsigned hold_count     = 0;
   int unsigned hold_seen      = 0;
   int unsigned ready_wait     = 0;
   bit          idle_on        = 1'b1;

   multilevel_queue_fcfs_scheduler dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Free-running clock.
   always #CLK_HALF clock = ~clock;

   // Guard against a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[multilevel_queue_fcfs_scheduler] ERROR");
         $finish;
      end
   end

   // Serves one class in arrival order, equal arrivals in load order, from start_tick.
   function automatic int unsigned serve_class(input logic cls, input int unsigned start_tick);
      int          order[MAX_PROCS];
      int          n;
      int          j;
      int unsigned now;
      n   = 0;
      now = start_tick;
      foreach (loaded_recs[i]) begin
         if (loaded_recs[i].kind == cls) begin
            j = n;
            while (j > 0 && loaded_recs[order[j-1]].arrival > loaded_recs[i].arrival) begin
               order[j] = order[j-1];
               j--;
            end
            order[j] = i;
            n++;
         end
      end
      for (int k = 0; k < n; k++) begin
         if (now < loaded_recs[order[k]].arrival) begin
            now = loaded_recs[order[k]].arrival;
         end
         now += loaded_recs[order[k]].burst;
         if (now > TIME_MAX) begin
            now = TIME_MAX;
         end
         finish_tick[order[k]] = now[TIME_W-1:0];
      end
      return now;
   endfunction

   // Schedules the loaded run and queues one result per stored record.
   function automatic void predict_run();
      int unsigned       now;
      rsp_type           res;
      logic [TIME_W-1:0] span;
      now = serve_class(CLASS_SYSTEM, 0);
      now = serve_class(CLASS_USER, now);
      foreach (loaded_recs[i]) begin
         span            = finish_tick[i] - loaded_recs[i].arrival;
         res.out_proc_id = loaded_recs[i].proc_id;
         res.out_arrival = loaded_recs[i].arrival;
         res.out_burst   = loaded_recs[i].burst;
         res.completion  = finish_tick[i];
         res.turnaround  = span;
         res.waiting     = (span >= loaded_recs[i].burst) ? span - loaded_recs[i].burst : '0;
         res.out_last    = (i == loaded_recs.size() - 1);
         schedule_q.push_back(res);
      end
      loaded_recs.delete();
   endfunction

   // A full store drops the record, but a final record still starts the run.
   function automatic void accept_record(input req_type rec);
      if (loaded_recs.size() < MAX_PROCS) begin
         loaded_recs.push_back(rec);
      end
      if (rec.last) begin
         predict_run();
      end
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic void check_result(input rsp_type got);
      rsp_type want;
      if (schedule_q.size() == 0) begin
         $error("result for process %0d with none outstanding", got.out_proc_id);
         mismatch_count++;
      end else begin
         want = schedule_q.pop_front();
         check_field("out_proc_id", want.out_proc_id, got.out_proc_id);
         check_field("out_arrival", want.out_arrival, got.out_arrival);
         check_field("out_burst", want.out_burst, got.out_burst);
         check_field("completion", want.completion, got.completion);
         check_field("turnaround", want.turnaround, got.turnaround);
         check_field("waiting", want.waiting, got.waiting);
         check_field("out_last", want.out_last, got.out_last);
      end
   endfunction

   // Result side: checks each transfer, then draws a stall or serves a long hold.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_result(rsp_data);
            ready_wait = idle_on ? $urandom_range(0, 4) : 0;
         end
         if (hold_seen != hold_count) begin
            hold_seen  = hold_count;
            ready_wait = HOLD_CYCLES;
         end
         if (ready_wait > 0) begin
            ready_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Offers one record after an optional gap and waits for its transfer.
   task automatic send_record(input req_type rec);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rec;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      accept_record(rec);
      records_sent++;
   endtask

   task automatic rest_request();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type make_record(input logic [15:0] id, input logic [15:0] arr,
                                           input logic [15:0] bur, input logic cls,
                                           input logic fin);
      req_type rec;
      rec.proc_id = id;
      rec.arrival = arr;
      rec.burst   = bur;
      rec.kind    = cls;
      rec.last    = fin;
      return rec;
   endfunction

   // Arrivals are mostly close together so that ties and queueing are common.
   function automatic req_type random_record(input logic fin);
      req_type rec;
      rec.proc_id = 16'($urandom);
      rec.arrival = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
      case ($urandom_range(0, 7))
         0:       rec.burst = '0;
         1, 2:    rec.burst = 16'($urandom);
         default: rec.burst = 16'($urandom_range(1, 30));
      endcase
      rec.kind = 1'($urandom);
      rec.last = fin;
      return rec;
   endfunction

   task automatic send_random_run(input int unsigned size);
      for (int n = 1; n < size; n++) send_record(random_record(1'b0));
      send_record(random_record(1'b1));
   endtask

   // Field extremes, zero bursts, both classes and an arrival tie in one run.
   task automatic test_extremes();
      send_record(make_record(16'h0000, 16'h0000, 16'h0000, CLASS_USER, 1'b0));
      send_record(make_record(16'hFFFF, 16'hFFFF, 16'hFFFF, CLASS_SYSTEM, 1'b0));
      send_record(make_record(16'h1234, 16'h0005, 16'h000A, CLASS_SYSTEM, 1'b0));
      send_record(make_record(16'h0ABC, 16'h0005, 16'h0003, CLASS_SYSTEM, 1'b0));
      send_record(make_record(16'h0DEF, 16'h0000, 16'h0000, CLASS_USER, 1'b0));
      send_record(make_record(16'h5555, 16'hFFFF, 16'hFFFF, CLASS_USER, 1'b1));
   endtask

   // A run of one record, which is also the last result.
   task automatic test_single_record();
      send_record(make_record(16'hFFFF, 16'h00FF, 16'h0100, CLASS_SYSTEM, 1'b1));
   endtask

   // The processor goes idle and the clock jumps to the next arrival.
   task automatic test_idle_jump();
      send_record(make_record(16'h0101, 16'd100, 16'd5, CLASS_SYSTEM, 1'b0));
      send_record(make_record(16'h0102, 16'd0, 16'd5, CLASS_SYSTEM, 1'b0));
      send_record(make_record(16'h0103, 16'd20, 16'd0, CLASS_USER, 1'b0));
      send_record(make_record(16'h0104, 16'd300, 16'd4, CLASS_USER, 1'b0));
      send_record(make_record(16'h0105, 16'd300, 16'd2, CLASS_USER, 1'b0));
      send_record(make_record(16'h0106, 16'd300, 16'd1, CLASS_USER, 1'b1));
   endtask

   // No system class records: user class starts from tick zero.
   task automatic test_user_only();
      send_record(make_record(16'h0201, 16'd7, 16'd3, CLASS_USER, 1'b0));
      send_record(make_record(16'h0202, 16'd3, 16'd9, CLASS_USER, 1'b0));
      send_record(make_record(16'h0203, 16'd7, 16'd1, CLASS_USER, 1'b1));
   endtask

   // More records than the store holds, the final one among those dropped.
   task automatic test_store_full();
      idle_on = 1'b0;
      send_random_run(MAX_PROCS + 3);
      idle_on = 1'b1;
      send_random_run(MAX_PROCS);
   endtask

   // The result side holds off while the next run is offered, so the input stalls.
   task automatic test_input_stall();
      send_random_run(6);
      hold_count <= hold_count + 1;
      send_random_run(12);
   endtask

   // Random runs, mostly short, with stretches that have no idling.
   task automatic test_random_runs();
      int unsigned size;
      while (records_sent < TOTAL_ITEMS) begin
         idle_on = ($urandom_range(0, 3) != 0);
         size    = ($urandom_range(0, 7) == 0) ? $urandom_range(16, MAX_PROCS)
                                               : $urandom_range(1, 8);
         send_random_run(size);
      end
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_extremes();
      test_single_record();
      test_idle_jump();
      test_user_only();
      test_store_full();
      test_input_stall();
      test_random_runs();
      rest_request();
      while (schedule_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[multilevel_queue_fcfs_scheduler] OK");
      end else begin
         $display("[multilevel_queue_fcfs_scheduler] ERROR");
      end
      $finish;
   end

endmodule
